[rtl/u2rtf_pkg.sv]
// Shared types, constants and character helpers for the UTF-8 to RTF escaper.
`timescale 1ns / 1ps
package u2rtf_pkg;

   // Kind of tail output that follows the leading replacement escapes of a command
   typedef enum logic [2:0] {
      K_NONE,
      K_CHAR,
      K_WORD,
      K_UNIT1,
      K_UNIT2,
      K_HEX
   } kind_type;

   typedef struct packed {
      logic [2:0]  fffd_cnt;  // number of \u-3? escapes emitted first
      kind_type    kind;
      logic        esc;       // K_CHAR: prefix a backslash
      logic        is_tab;    // K_WORD: \tab instead of \line
      logic [7:0]  ch;        // K_CHAR / K_HEX byte
      logic [15:0] u0;        // first 16-bit unit
      logic [15:0] u1;        // low surrogate for K_UNIT2
   } cmd_type;

   localparam int FifoDepth = 4;
   localparam int FifoAw    = $clog2(FifoDepth);

   localparam logic [15:0] Replacement = 16'hfffd;

   localparam logic [7:0] ChBslash = 8'h5c;
   localparam logic [7:0] ChU      = 8'h75;
   localparam logic [7:0] ChMinus  = 8'h2d;
   localparam logic [7:0] ChQmark  = 8'h3f;
   localparam logic [7:0] ChQuote  = 8'h27;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChSemi   = 8'h3b;
   localparam logic [7:0] ChLbrace = 8'h7b;
   localparam logic [7:0] ChRbrace = 8'h7d;
   localparam logic [7:0] ChLf     = 8'h0a;
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChCr     = 8'h0d;
   localparam logic [7:0] ChDel    = 8'h7f;

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + {4'd0, n};
      else return 8'h57 + {4'd0, n};
   endfunction

   // "\line " or "\tab ", one character per index
   function automatic logic [7:0] word_char(input logic is_tab, input logic [2:0] idx);
      logic [7:0] c;
      c = ChSpace;
      if (is_tab) begin
         case (idx)
            3'd0: c = ChBslash;
            3'd1: c = 8'h74;
            3'd2: c = 8'h61;
            3'd3: c = 8'h62;
            default: c = ChSpace;
         endcase
      end else begin
         case (idx)
            3'd0: c = ChBslash;
            3'd1: c = 8'h6c;
            3'd2: c = 8'h69;
            3'd3: c = 8'h6e;
            3'd4: c = 8'h65;
            default: c = ChSpace;
         endcase
      end
      return c;
   endfunction

   function automatic logic [2:0] word_last(input logic is_tab);
      return is_tab ? 3'd4 : 3'd5;
   endfunction

   function automatic logic [15:0] pow10(input logic [2:0] pos);
      logic [15:0] p;
      case (pos)
         3'd0: p = 16'd1;
         3'd1: p = 16'd10;
         3'd2: p = 16'd100;
         3'd3: p = 16'd1000;
         default: p = 16'd10000;
      endcase
      return p;
   endfunction

endpackage

[rtl/u2rtf_front.sv]
// Front end: UTF-8 sequence tracking and classification of each byte into an output command.
`timescale 1ns / 1ps
module u2rtf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 font_mode,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_byte,
   input  logic                 req_end,
   input  logic                 fifo_full,
   output logic                 push,
   output u2rtf_pkg::cmd_type   cmd
);
   import u2rtf_pkg::*;

   logic [2:0]  need_ff, need_in;
   logic [2:0]  fill_ff, fill_in;
   logic [14:0] acc_ff, acc_in;

   logic [20:0] cp;
   logic [2:0]  fill_nx;
   logic [2:0]  lead_len;
   logic        cp_ok;
   logic        do_fresh;
   logic        tail_en;
   logic [20:0] tail_cp;
   logic [19:0] sup;
   logic [7:0]  fch;
   logic [7:0]  tch;
   logic        accept;

   assign req_ready = !fifo_full;
   assign accept    = req_valid && !fifo_full;

   assign cp      = {acc_ff, req_byte[5:0]};
   assign fill_nx = 3'(fill_ff + 3'd1);

   always_comb begin
      case (req_byte) inside
         [8'hc2:8'hdf]: lead_len = 3'd2;
         [8'he0:8'hef]: lead_len = 3'd3;
         [8'hf0:8'hf4]: lead_len = 3'd4;
         default:       lead_len = 3'd0;
      endcase
   end

   always_comb begin
      cp_ok = (cp <= 21'h10ffff) && !(cp >= 21'h00d800 && cp <= 21'h00dfff);
      if (need_ff == 3'd2 && cp < 21'h80) cp_ok = 1'b0;
      if (need_ff == 3'd3 && cp < 21'h800) cp_ok = 1'b0;
      if (need_ff == 3'd4 && cp < 21'h10000) cp_ok = 1'b0;
   end

   always_comb begin
      need_in  = need_ff;
      fill_in  = fill_ff;
      acc_in   = acc_ff;
      cmd      = '0;
      cmd.kind = K_NONE;
      do_fresh = 1'b0;
      tail_en  = 1'b0;
      tail_cp  = '0;
      sup      = '0;
      tch      = '0;
      fch      = req_byte;

      if (font_mode) begin
         need_in = '0;
         fill_in = '0;
         if (req_byte < ChSpace || req_byte == ChDel || req_byte == ChSemi) fch = ChSpace;
         cmd.ch = fch;
         if (fch[7] || fch == ChBslash || fch == ChLbrace || fch == ChRbrace)
            cmd.kind = K_HEX;
         else
            cmd.kind = K_CHAR;
      end else if (need_ff == 3'd0) begin
         do_fresh = 1'b1;
      end else if (req_byte[7:6] != 2'b10) begin
         // broken sequence: one escape per buffered byte, then decode this byte afresh
         cmd.fffd_cnt = fill_ff;
         need_in      = '0;
         fill_in      = '0;
         do_fresh     = 1'b1;
      end else if (fill_nx == need_ff) begin
         need_in = '0;
         fill_in = '0;
         if (cp_ok) begin
            tail_en = 1'b1;
            tail_cp = cp;
         end else begin
            cmd.fffd_cnt = need_ff;
         end
      end else if (req_end) begin
         cmd.fffd_cnt = fill_nx;
         need_in      = '0;
         fill_in      = '0;
      end else begin
         fill_in = fill_nx;
         acc_in  = cp[14:0];
      end

      if (do_fresh) begin
         if (!req_byte[7]) begin
            tail_en = 1'b1;
            tail_cp = {13'd0, req_byte};
         end else if (lead_len == 3'd0 || req_end) begin
            cmd.fffd_cnt = 3'(cmd.fffd_cnt + 3'd1);
         end else begin
            need_in = lead_len;
            fill_in = 3'd1;
            case (lead_len)
               3'd2:    acc_in = {10'd0, req_byte[4:0]};
               3'd3:    acc_in = {11'd0, req_byte[3:0]};
               default: acc_in = {12'd0, req_byte[2:0]};
            endcase
         end
      end

      if (tail_en) begin
         if (tail_cp < 21'h80) begin
            tch    = {1'b0, tail_cp[6:0]};
            cmd.ch = tch;
            case (tch)
               ChBslash, ChLbrace, ChRbrace: begin
                  cmd.kind = K_CHAR;
                  cmd.esc  = 1'b1;
               end
               ChLf: cmd.kind = K_WORD;
               ChTab: begin
                  cmd.kind   = K_WORD;
                  cmd.is_tab = 1'b1;
               end
               ChCr: cmd.kind = K_NONE;
               default: begin
                  if (tch < ChSpace) cmd.fffd_cnt = 3'(cmd.fffd_cnt + 3'd1);
                  else cmd.kind = K_CHAR;
               end
            endcase
         end else if (tail_cp <= 21'hffff) begin
            cmd.kind = K_UNIT1;
            cmd.u0   = tail_cp[15:0];
         end else begin
            // split into a surrogate pair
            sup      = 20'(tail_cp - 21'h10000);
            cmd.kind = K_UNIT2;
            cmd.u0   = 16'hd800 | {6'd0, sup[19:10]};
            cmd.u1   = 16'hdc00 | {6'd0, sup[9:0]};
         end
      end
   end

   assign push = accept && (cmd.fffd_cnt != 3'd0 || cmd.kind != K_NONE);

   always_ff @(posedge clock) begin
      if (accept) acc_ff <= acc_in;
      if (reset) begin
         need_ff <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         need_ff <= need_in;
         fill_ff <= fill_in;
      end
   end

endmodule

[rtl/u2rtf_cmd_fifo.sv]
// Short command queue between the classifier and the character sequencer.
`timescale 1ns / 1ps
module u2rtf_cmd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  u2rtf_pkg::cmd_type   push_data,
   output logic                 full,
   input  logic                 pop,
   output u2rtf_pkg::cmd_type   head,
   output logic                 not_empty
);
   import u2rtf_pkg::*;

   cmd_type             mem_ff [FifoDepth];
   logic [FifoAw-1:0]   wr_ptr_ff;
   logic [FifoAw-1:0]   rd_ptr_ff;
   logic [FifoAw:0]     count_ff;

   assign full      = count_ff == (FifoAw + 1)'(FifoDepth);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= FifoAw'(wr_ptr_ff + 1'b1);
         if (pop) rd_ptr_ff <= FifoAw'(rd_ptr_ff + 1'b1);
         if (push && !pop) count_ff <= (FifoAw + 1)'(count_ff + 1'b1);
         else if (pop && !push) count_ff <= (FifoAw + 1)'(count_ff - 1'b1);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("command pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("command popped from empty queue");
`endif

endmodule

[rtl/u2rtf_back.sv]
// Back end: expands one queued command into RTF characters, one beat per cycle unless the output stalls.
`timescale 1ns / 1ps
module u2rtf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  u2rtf_pkg::cmd_type   cmd,
   output logic                 cmd_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast
);
   import u2rtf_pkg::*;

   typedef enum logic [3:0] {
      S_START, S_TAIL, S_UBS, S_UU, S_UNEG, S_UDIG, S_UQ,
      S_CHR, S_WORD, S_HEX_Q, S_HEX_HI, S_HEX_LO
   } state_type;

   typedef enum logic [1:0] {STG_FFFD, STG_TAIL, STG_LOW} stage_type;

   state_type   st_ff, st_in;
   stage_type   stage_ff, stage_in;
   logic [2:0]  left_ff, left_in;
   logic        neg_ff, neg_in;
   logic [15:0] rem_ff, rem_in;
   logic [2:0]  pos_ff, pos_in;
   logic [2:0]  widx_ff, widx_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;

   logic        advance;
   logic        emit;
   logic [7:0]  ch;
   logic        last;
   logic        tail_first;
   logic        load_en;
   logic [15:0] load_v;
   logic [15:0] mag;
   logic [15:0] p10;
   logic [3:0]  dig;
   logic [16:0] sel_m;

   assign advance = !out_valid_ff || rsp_tready;
   assign emit    = advance && cmd_valid;

   // current decimal digit: largest multiple of the place value not above the remainder
   always_comb begin
      p10   = pow10(pos_ff);
      dig   = '0;
      sel_m = '0;
      for (int k = 1; k < 10; k++) begin
         if ({1'b0, rem_ff} >= 17'(k) * {1'b0, p10}) begin
            dig   = 4'(k);
            sel_m = 17'(k) * {1'b0, p10};
         end
      end
   end

   always_comb begin
      st_in      = st_ff;
      stage_in   = stage_ff;
      left_in    = left_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      pos_in     = pos_ff;
      widx_in    = widx_ff;
      ch         = ChBslash;
      last       = 1'b0;
      cmd_pop    = 1'b0;
      tail_first = 1'b0;
      load_en    = 1'b0;
      load_v     = Replacement;
      mag        = '0;

      if (emit) begin
         case (st_ff)
            S_START: begin
               if (cmd.fffd_cnt != 3'd0) begin
                  load_en  = 1'b1;
                  stage_in = STG_FFFD;
                  left_in  = 3'(cmd.fffd_cnt - 3'd1);
               end else begin
                  tail_first = 1'b1;
               end
            end
            S_TAIL: tail_first = 1'b1;
            S_UBS: begin
               load_en = 1'b1;
               if (stage_ff == STG_LOW) load_v = cmd.u1;
               else if (stage_ff == STG_TAIL) load_v = cmd.u0;
            end
            S_UU: begin
               ch    = ChU;
               st_in = neg_ff ? S_UNEG : S_UDIG;
            end
            S_UNEG: begin
               ch    = ChMinus;
               st_in = S_UDIG;
            end
            S_UDIG: begin
               ch     = ChZero + {4'd0, dig};
               rem_in = 16'(({1'b0, rem_ff}) - sel_m);
               if (pos_ff == 3'd0) st_in = S_UQ;
               else pos_in = 3'(pos_ff - 3'd1);
            end
            S_UQ: begin
               ch = ChQmark;
               if (stage_ff == STG_FFFD && left_ff != 3'd0) begin
                  left_in = 3'(left_ff - 3'd1);
                  st_in   = S_UBS;
               end else if (stage_ff == STG_FFFD && cmd.kind != K_NONE) begin
                  st_in = S_TAIL;
               end else if (stage_ff == STG_TAIL && cmd.kind == K_UNIT2) begin
                  stage_in = STG_LOW;
                  st_in    = S_UBS;
               end else begin
                  last    = 1'b1;
                  cmd_pop = 1'b1;
                  st_in   = S_START;
               end
            end
            S_CHR: begin
               ch      = cmd.ch;
               last    = 1'b1;
               cmd_pop = 1'b1;
               st_in   = S_START;
            end
            S_WORD: begin
               ch = word_char(cmd.is_tab, widx_ff);
               if (widx_ff == word_last(cmd.is_tab)) begin
                  last    = 1'b1;
                  cmd_pop = 1'b1;
                  st_in   = S_START;
               end else begin
                  widx_in = 3'(widx_ff + 3'd1);
               end
            end
            S_HEX_Q: begin
               ch    = ChQuote;
               st_in = S_HEX_HI;
            end
            S_HEX_HI: begin
               ch    = hex_char(cmd.ch[7:4]);
               st_in = S_HEX_LO;
            end
            S_HEX_LO: begin
               ch      = hex_char(cmd.ch[3:0]);
               last    = 1'b1;
               cmd_pop = 1'b1;
               st_in   = S_START;
            end
            default: st_in = S_START;
         endcase

         if (tail_first) begin
            case (cmd.kind)
               K_CHAR: begin
                  if (cmd.esc) begin
                     st_in = S_CHR;
                  end else begin
                     ch      = cmd.ch;
                     last    = 1'b1;
                     cmd_pop = 1'b1;
                     st_in   = S_START;
                  end
               end
               K_WORD: begin
                  widx_in = 3'd1;
                  st_in   = S_WORD;
               end
               K_UNIT1, K_UNIT2: begin
                  load_en  = 1'b1;
                  load_v   = cmd.u0;
                  stage_in = STG_TAIL;
               end
               K_HEX: st_in = S_HEX_Q;
               default: begin
                  last    = 1'b1;
                  cmd_pop = 1'b1;
                  st_in   = S_START;
               end
            endcase
         end

         // latch a 16-bit unit as sign, magnitude and leading digit place
         if (load_en) begin
            neg_in = load_v[15];
            mag    = load_v[15] ? 16'(17'h10000 - {1'b0, load_v}) : load_v;
            rem_in = mag;
            if (mag >= 16'd10000) pos_in = 3'd4;
            else if (mag >= 16'd1000) pos_in = 3'd3;
            else if (mag >= 16'd100) pos_in = 3'd2;
            else if (mag >= 16'd10) pos_in = 3'd1;
            else pos_in = 3'd0;
            st_in = S_UU;
         end
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = emit;
         out_data_in  = ch;
         out_last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      widx_ff     <= widx_in;
      left_ff     <= left_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         st_ff        <= S_START;
         stage_ff     <= STG_FFFD;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         stage_ff     <= stage_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (rsp_tvalid && rsp_tlast))
      else $error("command retired without a last beat");
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_UDIG) |-> (pos_ff <= 3'd4))
      else $error("decimal place out of range");
`endif

endmodule

[rtl/utf8_to_rtf_escape_core.sv]
// Top level of the UTF-8 to RTF escaper: mode register, classifier, queue and sequencer.
`timescale 1ns / 1ps
// Each input beat is one UTF-8 byte (tlast marks the end of the text); the
// output gives one RTF character per beat, tlast on the last character that
// byte causes. The classifier takes one byte per cycle while its four-entry
// command queue has room; the sequencer emits one character per cycle while
// the output is not stalled. A byte produces 1 character for plain ASCII,
// 4 to 6 for control words and hex escapes, 5 to 9 for each \uN? unit, up to
// 21 for a broken four-byte sequence. Bytes that only extend a sequence, and
// carriage returns, produce nothing. The mode register must be written through
// the csr channel only while the block is idle; the block does not enforce it.
module utf8_to_rtf_escape_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // text_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // run_last
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // font_name_mode
);
   import u2rtf_pkg::*;

   logic    font_mode_ff;
   logic    push;
   logic    pop;
   logic    full;
   logic    not_empty;
   cmd_type push_cmd;
   cmd_type head_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) font_mode_ff <= 1'b0;
      else if (csr_valid) font_mode_ff <= csr_data;
   end

   u2rtf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .font_mode (font_mode_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_byte  (req_tdata),
      .req_end   (req_tlast),
      .fifo_full (full),
      .push      (push),
      .cmd       (push_cmd)
   );

   u2rtf_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (full),
      .pop       (pop),
      .head      (head_cmd),
      .not_empty (not_empty)
   );

   u2rtf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (not_empty),
      .cmd        (head_cmd),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
